// ===== hdl/mrp_pkg.sv =====
// shared types and constants for the midi receive parser
// no dependencies
package mrp_pkg;

  localparam int unsigned STEPS_PER_BAR_DEF = 96;
  localparam int unsigned BAR_W             = 7;
  localparam int unsigned VAL_W             = 7;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = 4;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL           = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ENABLE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTINUE_AS_START = 2'd2;

  // stored running status codes
  localparam logic [7:0] ST_IGNORE     = 8'h00;
  localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
  localparam logic [7:0] ST_NOTE_ON    = 8'h90;
  localparam logic [7:0] ST_CONTROL    = 8'hB0;
  localparam logic [7:0] ST_PROGRAM    = 8'hC0;
  localparam logic [7:0] ST_CHAN_PRESS = 8'hD0;
  localparam logic [7:0] ST_SONG_POS   = 8'hF2;
  localparam logic [7:0] ST_SYS_FIRST  = 8'hF0;

  // realtime bytes
  localparam logic [7:0] RT_FIRST    = 8'hF8;
  localparam logic [7:0] RT_CLOCK    = 8'hF8;
  localparam logic [7:0] RT_START    = 8'hFA;
  localparam logic [7:0] RT_CONTINUE = 8'hFB;
  localparam logic [7:0] RT_STOP     = 8'hFC;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_NOTE_ON  = 3'd1,
    EV_NOTE_OFF = 3'd2,
    EV_CONTROL  = 3'd3,
    EV_PROGRAM  = 3'd4,
    EV_SONG_POS = 3'd5,
    EV_START    = 3'd6,
    EV_STOP     = 3'd7
  } ev_kind_t;

  // message decoder result toward the transport and the output stage
  typedef struct packed {
    ev_kind_t               kind;
    logic [VAL_W-1:0]       first_value;
    logic [VAL_W-1:0]       second_value;
    logic                   bar_load;
    logic [BAR_W-1:0]       bar_value;
  } msg_evt_t;

  function automatic logic is_realtime(input logic [7:0] b);
    is_realtime = (b >= RT_FIRST);
  endfunction

endpackage

// ===== hdl/mrp_msg_decode.sv =====
// running status, data byte counter and channel message decode
// depends on mrp_pkg
module mrp_msg_decode #(
  parameter int unsigned STEPS_PER_BAR = mrp_pkg::STEPS_PER_BAR_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        rx_byte,
  input  logic [3:0]        channel,
  output mrp_pkg::msg_evt_t evt
);

  logic [7:0]               running_status_r, running_status_nxt;
  logic                     data_pending_r, data_pending_nxt;
  logic [mrp_pkg::VAL_W-1:0] first_data_r, first_data_nxt;
  logic                     one_byte_msg;
  logic                     done;
  logic [10:0]              sp_prod;

  assign one_byte_msg = (running_status_r == mrp_pkg::ST_PROGRAM) ||
                        (running_status_r == mrp_pkg::ST_CHAN_PRESS);

  // song position lsb scaled to bar steps
  assign sp_prod = 11'(first_data_r[3:0]) * 11'(STEPS_PER_BAR);

  always_comb begin
    running_status_nxt = running_status_r;
    data_pending_nxt   = data_pending_r;
    first_data_nxt     = first_data_r;
    done               = 1'b0;
    evt                = '0;
    evt.kind           = mrp_pkg::EV_NONE;
    evt.bar_value      = sp_prod[10:4];
    if (rx_byte[7]) begin
      if (mrp_pkg::is_realtime(rx_byte)) begin
        // realtime leaves the running status alone
      end else if (rx_byte >= mrp_pkg::ST_SYS_FIRST) begin
        running_status_nxt = rx_byte;
        data_pending_nxt   = 1'b0;
      end else if (rx_byte[3:0] == channel) begin
        running_status_nxt = {rx_byte[7:4], 4'h0};
        data_pending_nxt   = 1'b0;
      end else begin
        running_status_nxt = mrp_pkg::ST_IGNORE;
      end
    end else begin
      if (one_byte_msg) begin
        done = 1'b1;
      end else if (!data_pending_r) begin
        first_data_nxt   = rx_byte[6:0];
        data_pending_nxt = 1'b1;
      end else begin
        done = 1'b1;
      end
      if (done) begin
        data_pending_nxt = 1'b0;
        unique case (running_status_r)
          mrp_pkg::ST_NOTE_ON: begin
            evt.kind         = (rx_byte[6:0] != '0) ? mrp_pkg::EV_NOTE_ON
                                                    : mrp_pkg::EV_NOTE_OFF;
            evt.first_value  = first_data_r;
            evt.second_value = rx_byte[6:0];
          end
          mrp_pkg::ST_NOTE_OFF: begin
            evt.kind         = mrp_pkg::EV_NOTE_OFF;
            evt.first_value  = first_data_r;
            evt.second_value = rx_byte[6:0];
          end
          mrp_pkg::ST_CONTROL: begin
            evt.kind         = mrp_pkg::EV_CONTROL;
            evt.first_value  = first_data_r;
            evt.second_value = rx_byte[6:0];
          end
          mrp_pkg::ST_PROGRAM: begin
            evt.kind        = mrp_pkg::EV_PROGRAM;
            evt.first_value = rx_byte[6:0];
          end
          mrp_pkg::ST_SONG_POS: begin
            evt.kind         = mrp_pkg::EV_SONG_POS;
            evt.first_value  = first_data_r;
            evt.second_value = rx_byte[6:0];
            evt.bar_load     = 1'b1;
          end
          default: begin
            // other messages complete silently
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_status_r <= mrp_pkg::ST_IGNORE;
      data_pending_r   <= 1'b0;
      first_data_r     <= '0;
    end else if (en) begin
      running_status_r <= running_status_nxt;
      data_pending_r   <= data_pending_nxt;
      first_data_r     <= first_data_nxt;
    end
  end

endmodule

// ===== hdl/mrp_transport.sv =====
// bar position counter, run flag and start/continue/stop handling
// depends on mrp_pkg
module mrp_transport #(
  parameter int unsigned STEPS_PER_BAR = mrp_pkg::STEPS_PER_BAR_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [7:0]                rx_byte,
  input  logic                      sync_enable,
  input  logic                      continue_as_start,
  input  logic                      bar_load,
  input  logic [mrp_pkg::BAR_W-1:0] bar_value,
  output logic [mrp_pkg::BAR_W-1:0] bar_nxt,
  output logic                      run_nxt,
  output mrp_pkg::ev_kind_t         rt_kind
);

  logic [mrp_pkg::BAR_W-1:0] bar_r;
  logic                      run_r;
  logic                      pending_r, pending_nxt;
  logic [mrp_pkg::BAR_W:0]   bar_inc;

  assign bar_inc = {1'b0, bar_r} + (mrp_pkg::BAR_W+1)'(run_r);

  always_comb begin
    bar_nxt     = bar_r;
    run_nxt     = run_r;
    pending_nxt = pending_r;
    rt_kind     = mrp_pkg::EV_NONE;
    if (mrp_pkg::is_realtime(rx_byte)) begin
      if (sync_enable) begin
        unique case (rx_byte)
          mrp_pkg::RT_START: begin
            bar_nxt     = '0;
            run_nxt     = 1'b1;
            pending_nxt = 1'b0;
            rt_kind     = mrp_pkg::EV_START;
          end
          mrp_pkg::RT_CONTINUE: begin
            run_nxt = 1'b1;
            if (continue_as_start) begin
              pending_nxt = 1'b0;
              rt_kind     = mrp_pkg::EV_START;
            end else begin
              pending_nxt = 1'b1;
            end
          end
          mrp_pkg::RT_STOP: begin
            run_nxt     = 1'b0;
            pending_nxt = 1'b0;
            rt_kind     = mrp_pkg::EV_STOP;
          end
          mrp_pkg::RT_CLOCK: begin
            if (bar_inc >= (mrp_pkg::BAR_W+1)'(STEPS_PER_BAR)) begin
              // bar wrap, an armed start fires here
              bar_nxt = '0;
              if (pending_r) begin
                pending_nxt = 1'b0;
                rt_kind     = mrp_pkg::EV_START;
              end
            end else begin
              bar_nxt = bar_inc[mrp_pkg::BAR_W-1:0];
            end
          end
          default: begin
            // remaining realtime bytes do nothing
          end
        endcase
      end
    end else if (bar_load) begin
      bar_nxt = bar_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_r     <= '0;
      run_r     <= 1'b0;
      pending_r <= 1'b0;
    end else if (en) begin
      bar_r     <= bar_nxt;
      run_r     <= run_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

// ===== hdl/midi_receive_parser.sv =====
// midi receive parser top level: input register, decode, result register
// depends on mrp_pkg, mrp_msg_decode, mrp_transport
//
// channel  direction  handshake            payload
// in_      sink       in_valid/in_stall    in_rx_byte
// out_     source     out_valid/out_stall  out_event_kind, out_first_value,
//                                          out_second_value, out_bar_position,
//                                          out_running
// cfg_     sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one byte per cycle sustained while out_stall is low; a byte goes from the input
// register into the result register, which drives the out_ ports, and each holds
// it while the stage after it cannot take it
// every byte gives exactly one result, event kind none when nothing happened
// rst_n is synchronous and active low; it clears all parser state and config
// out_stall holds the result register; the input register keeps taking
// bytes until it too holds an item that cannot move on
module midi_receive_parser #(
  parameter int unsigned STEPS_PER_BAR = mrp_pkg::STEPS_PER_BAR_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input byte channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_event_kind,
  output logic [mrp_pkg::VAL_W-1:0]      out_first_value,
  output logic [mrp_pkg::VAL_W-1:0]      out_second_value,
  output logic [mrp_pkg::BAR_W-1:0]      out_bar_position,
  output logic                           out_running,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrp_pkg::CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic [3:0] channel_r;
  logic       sync_enable_r;
  logic       continue_as_start_r;

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       in_xfer;
  logic       s1_adv;
  logic       out_free;

  // decode results
  mrp_pkg::msg_evt_t          dec_evt;
  mrp_pkg::ev_kind_t          rt_kind;
  mrp_pkg::ev_kind_t          kind_sel;
  logic [mrp_pkg::BAR_W-1:0]  bar_nxt;
  logic                       run_nxt;

  // result register
  logic                       out_valid_r;
  mrp_pkg::ev_kind_t          out_kind_r;
  logic [mrp_pkg::VAL_W-1:0]  out_v1_r;
  logic [mrp_pkg::VAL_W-1:0]  out_v2_r;
  logic [mrp_pkg::BAR_W-1:0]  out_bar_r;
  logic                       out_run_r;

  // config port, always ready; writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r           <= '0;
      sync_enable_r       <= 1'b0;
      continue_as_start_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mrp_pkg::CFG_CHANNEL:           channel_r           <= cfg_data[3:0];
        mrp_pkg::CFG_SYNC_ENABLE:       sync_enable_r       <= cfg_data[0];
        mrp_pkg::CFG_CONTINUE_AS_START: continue_as_start_r <= cfg_data[0];
        default: begin
          // unknown register index
        end
      endcase
    end
  end

  // pipeline flow: result slot frees when empty or taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // running status and channel message decode
  mrp_msg_decode #(
    .STEPS_PER_BAR(STEPS_PER_BAR)
  ) u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_adv),
    .rx_byte (s1_byte_r),
    .channel (channel_r),
    .evt     (dec_evt)
  );

  // realtime transport and bar position
  mrp_transport #(
    .STEPS_PER_BAR(STEPS_PER_BAR)
  ) u_transport (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (s1_adv),
    .rx_byte           (s1_byte_r),
    .sync_enable       (sync_enable_r),
    .continue_as_start (continue_as_start_r),
    .bar_load          (dec_evt.bar_load),
    .bar_value         (dec_evt.bar_value),
    .bar_nxt           (bar_nxt),
    .run_nxt           (run_nxt),
    .rt_kind           (rt_kind)
  );

  // realtime bytes report the transport event, all others the decoder's
  assign kind_sel = mrp_pkg::is_realtime(s1_byte_r) ? rt_kind : dec_evt.kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kind_r <= kind_sel;
      out_v1_r   <= dec_evt.first_value;
      out_v2_r   <= dec_evt.second_value;
      out_bar_r  <= bar_nxt;
      out_run_r  <= run_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_first_value  = out_v1_r;
  assign out_second_value = out_v2_r;
  assign out_bar_position = out_bar_r;
  assign out_running      = out_run_r;

  // bar position never reaches the wrap value
  a_bar_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (8'(out_bar_r) < 8'(STEPS_PER_BAR)))
    else $error("bar position out of range");

  // a start leaves the transport running, a stop leaves it halted
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == mrp_pkg::EV_START)) |-> out_run_r)
    else $error("start event without run flag");

  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == mrp_pkg::EV_STOP)) |-> !out_run_r)
    else $error("stop event with run flag set");

  // a byte only leaves the input register into a free result slot
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && !s1_adv) |=> (out_valid_r && $stable(out_kind_r)))
    else $error("held result overwritten");

endmodule
